### hw/rtl/su_pkg.sv
// Shared types, character constants and decode helpers for the symbol name unescaper.
`default_nettype none

package su_pkg;

    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam int unsigned HEX_RADIX = 16;

    typedef enum logic [2:0] {
        ST_PREFIX,
        ST_DECODE,
        ST_FLUSH_RD,
        ST_FLUSH_WR,
        ST_DRAIN
    } t_state;

    // Requests from the control sequencer to the lookahead window.
    typedef struct packed {
        logic       clear;
        logic       push;
        logic       push_end;
        logic       step;
        logic [7:0] data;
    } t_la_ctrl;

    // Word produced by the lookahead window.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_la_out;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] used;
    } t_dec;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Letters of either case share the low nibble, offset by nine.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c <= 8'h39) begin
            hex_val = c[3:0];
        end else begin
            hex_val = c[3:0] + 4'd9;
        end
    endfunction

    // Decide the first byte of a window of n bytes (n from 1 to 3).
    function automatic t_dec decide(input logic [7:0] w0, input logic [7:0] w1,
                                    input logic [7:0] w2, input logic [1:0] n,
                                    input logic at_end);
        t_dec r;
        logic [7:0] hexb;
        hexb   = 8'(hex_val(w1) * HEX_RADIX) + {4'd0, hex_val(w2)};
        r.data = w0;
        r.used = 2'd1;
        priority if (n == 2'd3 && w0 == CH_USCORE && w1 == CH_USCORE && w2 == CH_USCORE) begin
            r.data = CH_DOT;
            r.used = 2'd3;
        end else if (n[1] && w0 == CH_USCORE && w1 == CH_USCORE && (n == 2'd3 || at_end)) begin
            r.data = CH_SLASH;
            r.used = 2'd2;
        end else if (n == 2'd3 && w0 == CH_USCORE && is_hex(w1) && is_hex(w2)) begin
            r.data = hexb;
            r.used = 2'd3;
        end
        decide = r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/su_ram.sv
// Single-port-write, registered-read byte memory holding the name prefix.
`default_nettype none

module su_ram #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic [7:0]         o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/su_lookahead.sv
// Three-byte lookahead window that decodes escape sequences after the prefix.
`default_nettype none

module su_lookahead
    import su_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_la_ctrl i_ctrl,
    output t_la_out       o_out
);

    logic [7:0] r_w0, r_w1, r_w2;
    logic [7:0] n_w0, n_w1, n_w2;
    logic [1:0] r_n, n_n;
    logic [7:0] w0, w1, w2;
    logic [1:0] wn, rem;
    t_dec       dec;

    always_comb begin
        // A pushed byte lands right after the held ones.
        if (i_ctrl.push) begin
            w0 = (r_n == 2'd0) ? i_ctrl.data : r_w0;
            w1 = (r_n == 2'd1) ? i_ctrl.data : r_w1;
            w2 = (r_n == 2'd2) ? i_ctrl.data : r_w2;
            wn = r_n + 2'd1;
        end else begin
            w0 = r_w0;
            w1 = r_w1;
            w2 = r_w2;
            wn = r_n;
        end
        dec = decide(w0, w1, w2, wn, i_ctrl.step);
        rem = wn - dec.used;

        n_w0 = w0;
        n_w1 = w1;
        n_w2 = w2;
        n_n  = wn;
        o_out.valid = 1'b0;
        o_out.data  = dec.data;
        o_out.last  = 1'b0;

        if (i_ctrl.clear) begin
            n_n = 2'd0;
        end else if ((i_ctrl.push && !i_ctrl.push_end && wn == 2'd3) || i_ctrl.step) begin
            o_out.valid = 1'b1;
            o_out.last  = i_ctrl.step && (rem == 2'd0);
            n_w0 = (dec.used == 2'd1) ? w1 : w2;
            n_w1 = w2;
            n_n  = rem;
        end else if (!i_ctrl.push) begin
            n_n = r_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 2'd0;
        end else begin
            r_n <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w0 <= n_w0;
        r_w1 <= n_w1;
        r_w2 <= n_w2;
    end

endmodule

`default_nettype wire

### hw/rtl/symbol_name_unescaper.sv
// Streaming unescaper for mangled symbol names with a memory-held prefix.
// Output words are registered; the input is stalled during a prefix flush and the drain.
// Throughput: one byte per cycle while decoding and the output is ready; a prefix flush reads
// each stored byte through the memory's registered read port before sending it, and the
// end-of-name drain sends up to three words, one per cycle while the output is ready.
// Reset is synchronous, active low; the prefix memory is not cleared and is never read unwritten.
`default_nettype none

module symbol_name_unescaper
    import su_pkg::*;
#(
    parameter int NAME_BYTES = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire logic       i_s_tlast,   // end_of_name
    input  wire logic       i_s_tuser,   // [0] pass_through
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic            o_m_tlast,   // out_last
    output logic            o_m_tuser    // [0] prefix_overflow
);

    localparam int AW = $clog2(NAME_BYTES);
    localparam int CW = $clog2(NAME_BYTES + 1);

    t_state      r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_ptr, n_ptr;
    logic        r_ovf, n_ovf;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_odata, n_odata;
    logic        r_olast, n_olast;
    logic        r_oovf, n_oovf;

    logic        can_emit, acc, full, flush_last, emit;
    logic        ram_we, ram_re;
    logic [7:0]  ram_rdata;
    t_la_ctrl    la_ctrl;
    t_la_out     la_out;

    su_ram #(.DEPTH(NAME_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_s_tdata),
        .i_re    (ram_re),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    su_lookahead u_la (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (la_ctrl),
        .o_out   (la_out)
    );

    assign can_emit   = !r_ovalid || i_m_tready;
    assign o_s_tready = can_emit && (r_state == ST_PREFIX || r_state == ST_DECODE);
    assign acc        = i_s_tvalid && o_s_tready;
    assign full       = (r_cnt == CW'(NAME_BYTES));
    assign flush_last = (CW'(r_ptr) + CW'(1)) == r_cnt;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ptr    = r_ptr;
        n_ovf    = r_ovf;
        emit     = 1'b0;
        n_odata  = i_s_tdata;
        n_olast  = 1'b0;
        n_oovf   = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        la_ctrl  = '{clear: 1'b0, push: 1'b0, push_end: i_s_tlast, step: 1'b0,
                     data: i_s_tdata};

        unique case (r_state)
            ST_PREFIX: begin
                if (acc) begin
                    if (i_s_tuser) begin
                        emit    = 1'b1;
                        n_olast = i_s_tlast;
                        if (i_s_tlast) begin
                            n_cnt         = '0;
                            n_ovf         = 1'b0;
                            la_ctrl.clear = 1'b1;
                        end
                    end else if (i_s_tdata == CH_USCORE && !i_s_tlast) begin
                        n_state       = ST_DECODE;
                        n_cnt         = '0;
                        n_ovf         = 1'b0;
                        la_ctrl.clear = 1'b1;
                    end else begin
                        if (!full) begin
                            ram_we = 1'b1;
                            n_cnt  = r_cnt + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (i_s_tlast) begin
                            n_state = ST_FLUSH_RD;
                            n_ptr   = '0;
                        end
                    end
                end
            end
            ST_DECODE: begin
                if (acc) begin
                    if (i_s_tuser) begin
                        emit    = 1'b1;
                        n_olast = i_s_tlast;
                        if (i_s_tlast) begin
                            n_state       = ST_PREFIX;
                            la_ctrl.clear = 1'b1;
                        end
                    end else begin
                        la_ctrl.push = 1'b1;
                        emit         = la_out.valid;
                        n_odata      = la_out.data;
                        if (i_s_tlast) begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_FLUSH_RD: begin
                ram_re  = 1'b1;
                n_state = ST_FLUSH_WR;
            end
            ST_FLUSH_WR: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    n_odata = ram_rdata;
                    n_olast = flush_last;
                    n_oovf  = r_ovf;
                    if (flush_last) begin
                        n_state = ST_PREFIX;
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_ptr   = r_ptr + AW'(1);
                        n_state = ST_FLUSH_RD;
                    end
                end
            end
            ST_DRAIN: begin
                if (can_emit) begin
                    la_ctrl.step = 1'b1;
                    emit         = 1'b1;
                    n_odata      = la_out.data;
                    n_olast      = la_out.last;
                    if (la_out.last) begin
                        n_state = ST_PREFIX;
                    end
                end
            end
            default: begin
                n_state = ST_PREFIX;
            end
        endcase

        n_ovalid = emit ? 1'b1 : (i_m_tready ? 1'b0 : r_ovalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_PREFIX;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (emit) begin
            r_odata <= n_odata;
            r_olast <= n_olast;
            r_oovf  <= n_oovf;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_oovf;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NAME_BYTES))
        else $error("prefix count beyond store depth");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH_RD || r_state == ST_FLUSH_WR) |-> (CW'(r_ptr) < r_cnt))
        else $error("flush pointer outside stored prefix");

    a_decode_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREFIX && n_state == ST_DECODE) |=> (r_cnt == '0 && !r_ovf))
        else $error("prefix state not cleared on entering decode");

    a_overflow_only_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_oovf) |-> (r_state == ST_FLUSH_WR))
        else $error("overflow flag on a word outside a prefix flush");
`endif

endmodule

`default_nettype wire
